// ----- src/pcxd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pcxd_pkg;

   // Stream byte classes
   localparam logic [7:0] MARKER_MASK = 8'hC0;
   localparam logic [7:0] COUNT_MASK  = 8'h3F;

   // Request kinds
   localparam logic REQ_IMAGE   = 1'b0;
   localparam logic REQ_PALETTE = 1'b1;

   localparam int COLOR_W = 24;
   localparam int INDEX_W = 8;
   localparam int RUN_W   = 6;
   localparam int COUNT_W = 33;
   localparam int TOTAL_W = 32;

   // One decoded command: a pixel color repeated run times
   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [INDEX_W-1:0] index;
      logic [RUN_W-1:0]   run;
      logic               done;
   } cmd_type;

   // Front status seen by the top level
   typedef struct packed {
      logic finished;
      logic awaiting;
      logic stage_valid;
   } front_stat_type;

endpackage

`default_nettype wire

// ----- src/pcxd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pcxd_front
   import pcxd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic               req_type,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic [7:0]         req_pal_index,
   input  wire logic [23:0]        req_pal_color,
   input  wire logic [TOTAL_W-1:0] total,
   output logic                    cmd_valid,
   output cmd_type                 cmd,
   output front_stat_type          stat
);

   logic [COLOR_W-1:0] pal_mem [256];
   logic [COLOR_W-1:0] pal_rd_ff;

   logic               awaiting_ff, awaiting_in;
   logic [RUN_W-1:0]   run_len_ff, run_len_in;
   logic [COUNT_W-1:0] bytes_ff, bytes_in;
   logic               finished_ff, finished_in;

   logic               stg_valid_ff, stg_valid_in;
   logic [INDEX_W-1:0] stg_index_ff;
   logic [RUN_W-1:0]   stg_run_ff;
   logic               stg_done_ff, stg_done_in;

   logic               image_acc;
   logic [RUN_W-1:0]   run_n;
   logic [COUNT_W-1:0] bytes_sum;
   logic [COUNT_W-1:0] total_ext;

   assign image_acc = accept && (req_type == REQ_IMAGE) && !finished_ff;
   assign total_ext = {1'b0, total};
   assign run_n     = awaiting_ff ? run_len_ff : RUN_W'(1);
   assign bytes_sum = bytes_ff + COUNT_W'(run_n);

   // Classify the accepted image byte and advance the byte count
   always_comb begin
      awaiting_in  = awaiting_ff;
      run_len_in   = run_len_ff;
      bytes_in     = bytes_ff;
      finished_in  = finished_ff;
      stg_valid_in = 1'b0;
      stg_done_in  = (bytes_sum >= total_ext);
      if (image_acc) begin
         if (awaiting_ff) begin
            awaiting_in  = 1'b0;
            bytes_in     = bytes_sum;
            stg_valid_in = (run_len_ff != '0);
         end else if (bytes_ff >= total_ext) begin
            finished_in = 1'b1;
         end else if ((req_data_byte & MARKER_MASK) == MARKER_MASK) begin
            run_len_in  = RUN_W'(req_data_byte & COUNT_MASK);
            awaiting_in = 1'b1;
         end else begin
            bytes_in     = bytes_sum;
            stg_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff  <= 1'b0;
         run_len_ff   <= '0;
         bytes_ff     <= '0;
         finished_ff  <= 1'b0;
         stg_valid_ff <= 1'b0;
      end else begin
         awaiting_ff  <= awaiting_in;
         run_len_ff   <= run_len_in;
         bytes_ff     <= bytes_in;
         finished_ff  <= finished_in;
         stg_valid_ff <= stg_valid_in;
      end
   end

   // Hold the command fields for the palette read cycle
   always_ff @(posedge clock) begin
      if (image_acc) begin
         stg_index_ff <= req_data_byte;
         stg_run_ff   <= run_n;
         stg_done_ff  <= stg_done_in;
      end
   end

   // Palette: read ahead of any later write, write on palette transfers
   always_ff @(posedge clock) begin
      if (accept) begin
         pal_rd_ff <= pal_mem[req_data_byte];
         if (req_type == REQ_PALETTE) begin
            pal_mem[req_pal_index] <= req_pal_color;
         end
      end
   end

   assign cmd_valid        = stg_valid_ff;
   assign cmd.color        = pal_rd_ff;
   assign cmd.index        = stg_index_ff;
   assign cmd.run          = stg_run_ff;
   assign cmd.done         = stg_done_ff;
   assign stat.finished    = finished_ff;
   assign stat.awaiting    = awaiting_ff;
   assign stat.stage_valid = stg_valid_ff;

endmodule

`default_nettype wire

// ----- src/pcxd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pcxd_queue
   import pcxd_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      wr_en,
   input  wire cmd_type                   wr_data,
   input  wire logic                      rd_en,
   output cmd_type                        rd_data,
   output logic                           q_empty,
   output logic [$clog2(DEPTH+1)-1:0]     q_count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   cmd_type         slots [DEPTH];
   logic [PW-1:0]   head_ff, head_in;
   logic [PW-1:0]   tail_ff, tail_in;
   logic [CW-1:0]   count_ff, count_in;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (wr_en) begin
         tail_in = (tail_ff == PW'(DEPTH-1)) ? '0 : tail_ff + PW'(1);
      end
      if (rd_en) begin
         head_in = (head_ff == PW'(DEPTH-1)) ? '0 : head_ff + PW'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CW'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots[tail_ff] <= wr_data;
      end
   end

   assign rd_data = slots[head_ff];
   assign q_empty = (count_ff == '0);
   assign q_count = count_ff;

endmodule

`default_nettype wire

// ----- src/pcxd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pcxd_back
   import pcxd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             q_head,
   input  wire logic                q_empty,
   output logic                     q_pop,
   output logic                     empty,
   input  wire logic                pop,
   output logic [COLOR_W-1:0]       rsp_pixel_color,
   output logic [INDEX_W-1:0]       rsp_pixel_index,
   output logic                     rsp_last_in_run,
   output logic                     rsp_image_done
);

   logic               cur_valid_ff, cur_valid_in;
   cmd_type            cur_ff;
   logic [RUN_W-1:0]   rem_ff;

   logic               out_valid_ff, out_valid_in;
   logic [COLOR_W-1:0] out_color_ff;
   logic [INDEX_W-1:0] out_index_ff;
   logic               out_last_ff;
   logic               out_done_ff;

   cmd_type            src;
   logic               src_valid;
   logic [RUN_W-1:0]   rem;
   logic               out_free;
   logic               emit;
   logic               last;

   // Pick the run in progress, else the queue head
   assign src       = cur_valid_ff ? cur_ff : q_head;
   assign src_valid = cur_valid_ff || !q_empty;
   assign rem       = cur_valid_ff ? rem_ff : q_head.run;
   assign out_free  = !out_valid_ff || pop;
   assign emit      = src_valid && out_free;
   assign last      = (rem == RUN_W'(1));
   assign q_pop     = emit && !cur_valid_ff;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      if (emit) begin
         cur_valid_in = !last;
      end
      out_valid_in = emit || (out_valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Count down the run and load one pixel into the output register
   always_ff @(posedge clock) begin
      if (emit) begin
         cur_ff       <= src;
         rem_ff       <= rem - RUN_W'(1);
         out_color_ff <= src.color;
         out_index_ff <= src.index;
         out_last_ff  <= last;
         out_done_ff  <= src.done;
      end
   end

   assign empty           = !out_valid_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_pixel_index = out_index_ff;
   assign rsp_last_in_run = out_last_ff;
   assign rsp_image_done  = out_done_ff;

endmodule

`default_nettype wire

// ----- src/pcx_rle_palette_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         push / full          req_type, req_data_byte, req_pal_index,
//                                           req_pal_color
// rsp       out        empty / pop          rsp_pixel_color, rsp_pixel_index,
//                                           rsp_last_in_run, rsp_image_done
// csr       in         csr_valid/csr_ready  csr_data (total image bytes)
//
// The front takes one byte per cycle while full is low; a literal or run is classified
// into the palette read stage, then goes through the command queue to the output register.
// The back emits one pixel per cycle while its output register is free.
// full rises when the command queue plus the palette read stage hold QUEUE_DEPTH.
// Synchronous reset clears control state; the palette is undefined until written.

module pcx_rle_palette_decoder
   import pcxd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   output logic                     full,
   input  wire logic                req_type,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic [7:0]          req_pal_index,
   input  wire logic [23:0]         req_pal_color,
   output logic                     empty,
   input  wire logic                pop,
   output logic [23:0]              rsp_pixel_color,
   output logic [7:0]               rsp_pixel_index,
   output logic                     rsp_last_in_run,
   output logic                     rsp_image_done,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [31:0]         csr_data
);

   localparam int CW = $clog2(QUEUE_DEPTH+1);

   logic [TOTAL_W-1:0] total_ff;
   logic               accept;
   logic               cmd_valid;
   cmd_type            cmd;
   front_stat_type     stat;
   cmd_type            q_head;
   logic               q_empty;
   logic               q_pop;
   logic [CW-1:0]      q_count;
   logic [CW:0]        in_flight;

   // Total image bytes register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         total_ff <= csr_data;
      end
   end

   // Reserve a queue slot for the command in the palette read stage
   assign in_flight = {1'b0, q_count} + (CW+1)'(stat.stage_valid);
   assign full      = (in_flight >= (CW+1)'(QUEUE_DEPTH));
   assign accept    = push && !full;

   pcxd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_type      (req_type),
      .req_data_byte (req_data_byte),
      .req_pal_index (req_pal_index),
      .req_pal_color (req_pal_color),
      .total         (total_ff),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .stat          (stat)
   );

   pcxd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_valid),
      .wr_data (cmd),
      .rd_en   (q_pop),
      .rd_data (q_head),
      .q_empty (q_empty),
      .q_count (q_count)
   );

   pcxd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_head          (q_head),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_last_in_run (rsp_last_in_run),
      .rsp_image_done  (rsp_image_done)
   );

   // Queue never takes a command without room
   assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> (q_count < CW'(QUEUE_DEPTH)))
      else $error("command queue overflow");

   // Zero-length runs never reach the queue
   assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (q_head.run != '0))
      else $error("empty run queued");

   // Completion sticks until reset
   assert property (@(posedge clock) disable iff (reset)
      stat.finished |=> stat.finished)
      else $error("finished flag dropped");

   // A finished image issues no new commands
   assert property (@(posedge clock) disable iff (reset)
      stat.finished && !stat.stage_valid |=> !stat.stage_valid)
      else $error("command after image end");

endmodule

`default_nettype wire
